FILE: rtl/bwb_pkg.sv
package bwb_pkg;

	localparam int DEPTH     = 16;
	localparam int PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int DATA_W    = 32;
	localparam int CAP_W     = 5;
	localparam int POS_W     = 5;
	localparam int IDX_W     = 5;
	localparam int MODE_W    = 2;
	localparam int STATUS_W  = 2;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [CNT_W-1:0] cnt_t;

	localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DUMP   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;

	typedef struct packed {
		logic signed [DATA_W-1:0] value_res;
		logic [IDX_W-1:0]         index;
		logic [IDX_W-1:0]         count;
		logic [STATUS_W-1:0]      status;
		logic                     last;
	} res_t;

	// Map a logical position (oldest is 0) to a physical slot of the ring.
	function automatic ptr_t phys(input ptr_t head, input cnt_t lidx);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(head) + (CNT_W+1)'(lidx);
		if (s >= (CNT_W+1)'(DEPTH))
			s = s - (CNT_W+1)'(DEPTH);
		return s[PTR_W-1:0];
	endfunction

endpackage

FILE: rtl/bwb_ram.sv
module bwb_ram #(
	parameter int DEPTH  = 16,
	parameter int WIDTH  = 32,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	// Read data holds until the next read.
	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

FILE: rtl/bounded_window_buffer.sv
// Ordered window of up to "capacity" signed 32-bit values, oldest first, kept as a ring
// in one single-port-write / single-port-read memory with a head pointer and a fill count.
// Requests: add (mode 0) appends and, when the window is full, drops the oldest entries
// down to capacity; remove (mode 1) deletes the 1-based position and closes the gap;
// dump (mode 2) streams every entry oldest first with last set on the final one; an
// empty dump gives one result with status 2. Add and remove give one acknowledgment.
// Add, remove of the newest entry, a bad position, an empty dump and mode 3 are done
// without leaving the idle state. A remove elsewhere closes the gap by moving one entry
// per cycle through the memory read port, write-back overlapping the next read, and a
// final step writes back the last entry and ends the move. Each dumped entry passes a
// read state and then an output state, since the memory read is registered; the dump
// waits in the output state while the output buffer is full.
// Results leave through a two-entry output buffer, so a request is taken while one
// result still waits; outside the gap-close and dump states, a request is held off only
// when both entries are full.
// Capacity 0 acts as 1, above 16 acts as 16; a lowered capacity takes effect at the
// next add. Write capacity only while no request is in flight.
module bounded_window_buffer
	import bwb_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration
	input  logic                       cfg_wen,
	input  logic [CAP_W-1:0]           cfg_data,
	// request channel
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [MODE_W-1:0]          mode,
	input  logic signed [DATA_W-1:0]   value,
	input  logic [POS_W-1:0]           position,
	// result channel
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [DATA_W-1:0]   value_res,
	output logic [IDX_W-1:0]           index,
	output logic [IDX_W-1:0]           count,
	output logic [STATUS_W-1:0]        status,
	output logic                       last
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SHIFT = 4'b0010,
		S_DRD   = 4'b0100,
		S_DWR   = 4'b1000
	} state_t;

	state_t state_q, state_d;

	logic [CAP_W-1:0] cap_q;
	cnt_t             fill_q, fill_d;
	ptr_t             head_q, head_d;
	cnt_t             rd_q, rd_d;
	cnt_t             eff_cap;

	// gap-closing write-back stage
	logic             sh_v_s1;
	cnt_t             sh_idx_s1;

	// output buffer: head slot drives the ports, skid slot catches one more
	res_t             out_q, skid_q;
	logic             out_v_q, skid_v_q;
	logic             push, pop;
	res_t             res_d;

	// memory port
	logic              we, re;
	ptr_t              waddr, raddr;
	logic [DATA_W-1:0] wdata, rdata;

	logic in_acc;

	bwb_ram #(
		.DEPTH (DEPTH),
		.WIDTH (DATA_W),
		.ADDR_W(PTR_W)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign in_ready = (state_q == S_IDLE) && !skid_v_q;
	assign in_acc   = in_valid && in_ready;
	assign pop      = out_v_q && out_ready;

	// Clamp capacity into 1..DEPTH.
	always_comb begin
		if (cap_q == '0)
			eff_cap = cnt_t'(1);
		else if (int'(cap_q) > DEPTH)
			eff_cap = cnt_t'(DEPTH);
		else
			eff_cap = cnt_t'(cap_q);
	end

	always_comb begin
		state_d = state_q;
		fill_d  = fill_q;
		head_d  = head_q;
		rd_d    = rd_q;
		push    = 1'b0;
		res_d   = '0;
		we      = 1'b0;
		waddr   = phys(head_q, fill_q);
		wdata   = value;
		re      = 1'b0;
		raddr   = phys(head_q, rd_q);

		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					case (mode)
						MODE_ADD: begin
							// new entry lands at head + fill, just past the newest; when the window
							// is full the head moves past the dropped oldest entries
							if (fill_q >= eff_cap) begin
								head_d = phys(head_q, fill_q - eff_cap + cnt_t'(1));
								fill_d = eff_cap;
							end else begin
								fill_d = fill_q + cnt_t'(1);
							end
							we          = 1'b1;
							push        = 1'b1;
							res_d.count = IDX_W'(fill_d);
							res_d.last  = 1'b1;
						end
						MODE_REMOVE: begin
							push       = 1'b1;
							res_d.last = 1'b1;
							if (position == '0 || (CNT_W+1)'(position) > (CNT_W+1)'(fill_q)) begin
								res_d.status = ST_BADPOS;
								res_d.count  = IDX_W'(fill_q);
							end else begin
								res_d.count = IDX_W'(fill_q - cnt_t'(1));
								if ((CNT_W+1)'(position) == (CNT_W+1)'(fill_q)) begin
									fill_d = fill_q - cnt_t'(1);
								end else begin
									// close the gap starting with the entry after it
									rd_d    = cnt_t'(position);
									state_d = S_SHIFT;
								end
							end
						end
						MODE_DUMP: begin
							if (fill_q == '0) begin
								push         = 1'b1;
								res_d.status = ST_EMPTY;
								res_d.last   = 1'b1;
							end else begin
								rd_d    = '0;
								state_d = S_DRD;
							end
						end
						default: ;
					endcase
				end
			end
			S_SHIFT: begin
				// read entry rd, write back the one read last cycle one place lower
				if (rd_q != fill_q) begin
					re   = 1'b1;
					rd_d = rd_q + cnt_t'(1);
				end
				if (sh_v_s1) begin
					we    = 1'b1;
					waddr = phys(head_q, sh_idx_s1);
					wdata = rdata;
				end
				if (rd_q == fill_q) begin
					fill_d  = fill_q - cnt_t'(1);
					state_d = S_IDLE;
				end
			end
			S_DRD: begin
				re      = 1'b1;
				state_d = S_DWR;
			end
			S_DWR: begin
				// hold the read data until the output buffer has room
				if (!skid_v_q) begin
					push            = 1'b1;
					res_d.value_res = rdata;
					res_d.index     = IDX_W'(rd_q + cnt_t'(1));
					res_d.count     = IDX_W'(fill_q);
					res_d.status    = ST_OK;
					res_d.last      = (rd_q + cnt_t'(1) == fill_q);
					rd_d            = rd_q + cnt_t'(1);
					state_d         = res_d.last ? S_IDLE : S_DRD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			head_q  <= '0;
			rd_q    <= '0;
			cap_q   <= CAP_RESET;
			sh_v_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			head_q  <= head_d;
			rd_q    <= rd_d;
			sh_v_s1 <= (state_q == S_SHIFT) && (rd_q != fill_q);
			if (cfg_wen)
				cap_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		sh_idx_s1 <= rd_q - cnt_t'(1);
	end

	// Output buffer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_v_q) begin
					out_v_q  <= 1'b1;
					skid_v_q <= push;
				end else begin
					out_v_q  <= push;
				end
			end else if (!out_v_q) begin
				out_v_q <= push;
			end else if (push) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	// Output buffer payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q) begin
				out_q <= skid_q;
				if (push)
					skid_q <= res_d;
			end else if (push) begin
				out_q <= res_d;
			end
		end else if (!out_v_q) begin
			if (push)
				out_q <= res_d;
		end else if (push) begin
			skid_q <= res_d;
		end
	end

	assign out_valid = out_v_q;
	assign value_res = out_q.value_res;
	assign index     = out_q.index;
	assign count     = out_q.count;
	assign status    = out_q.status;
	assign last      = out_q.last;

endmodule

FILE: rtl/bwb_checker.sv
module bwb_checker
	import bwb_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic signed [DATA_W-1:0] value_res,
	input logic [IDX_W-1:0]         index,
	input logic [IDX_W-1:0]         count,
	input logic [STATUS_W-1:0]      status,
	input logic                     last
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value_res) && $stable(index)
			&& $stable(count) && $stable(status) && $stable(last))
		else $error("result changed while stalled");

	// acknowledgments and empty dumps carry no entry and close the request
	a_ack_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && index == '0 |-> last && value_res == '0)
		else $error("acknowledgment malformed");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> count == '0 && index == '0)
		else $error("empty status with entries");

	// dumped entries lie inside the window; last marks the newest
	a_dump_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && index != '0 |-> index <= count && status == ST_OK
			&& (last == (index == count)))
		else $error("dump index out of window");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> int'(count) <= DEPTH)
		else $error("count above depth");

endmodule

bind bounded_window_buffer bwb_checker u_bwb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.value_res(value_res),
	.index    (index),
	.count    (count),
	.status   (status),
	.last     (last)
);

FILE: bench/tb_bounded_window_buffer.sv
`timescale 1ns / 1ps

module tb_bounded_window_buffer;
	import bwb_pkg::*;

	// Mode 3 is not named in the package; the block swallows it without a result.
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	localparam int CYCLE_LIMIT     = 400000;
	// Longest internal activity after the last result: a full-depth gap close.
	localparam int SETTLE_CYCLES   = 48;

	// Window model: keeps its own copy of the entries and the capacity register and
	// turns every accepted request into the results the block owes for it.
	class window_scoreboard;
		logic signed [DATA_W-1:0] held[$];
		logic [CAP_W-1:0]         capacity;
		res_t                     awaited[$];
		int unsigned              errors;
		int unsigned              checked;

		function new();
			capacity = CAP_RESET;
			errors   = 0;
			checked  = 0;
		endfunction

		function void set_capacity(input logic [CAP_W-1:0] c);
			capacity = c;
		endfunction

		function int unsigned fill();
			return held.size();
		endfunction

		function int unsigned pending();
			return awaited.size();
		endfunction

		function void queue_result(input logic signed [DATA_W-1:0] v, input int unsigned idx,
				input logic [STATUS_W-1:0] st, input logic fin);
			res_t r;
			r.value_res = v;
			r.index     = IDX_W'(idx);
			r.count     = IDX_W'(held.size());
			r.status    = st;
			r.last      = fin;
			awaited.push_back(r);
		endfunction

		function void note_request(input logic [MODE_W-1:0] op,
				input logic signed [DATA_W-1:0] v, input logic [POS_W-1:0] pos);
			int unsigned keep;
			// Zero keeps one entry, anything above the depth keeps the depth.
			keep = (capacity == 0) ? 1 : (capacity > DEPTH) ? DEPTH : capacity;
			case (op)
				MODE_ADD: begin
					// A lowered capacity bites here: drop down below it, then append.
					while (held.size() >= keep)
						void'(held.pop_front());
					held.push_back(v);
					queue_result('0, 0, ST_OK, 1'b1);
				end
				MODE_REMOVE: begin
					if (pos == 0 || pos > held.size()) begin
						queue_result('0, 0, ST_BADPOS, 1'b1);
					end else begin
						held.delete(int'(pos) - 1);
						queue_result('0, 0, ST_OK, 1'b1);
					end
				end
				MODE_DUMP: begin
					if (held.size() == 0) begin
						queue_result('0, 0, ST_EMPTY, 1'b1);
					end else begin
						foreach (held[i])
							queue_result(held[i], i + 1, ST_OK, i == held.size() - 1);
					end
				end
				default: ;
			endcase
		endfunction

		function void check_result(input res_t got);
			res_t want;
			if (awaited.size() == 0) begin
				$display("%0t: result with nothing outstanding: value_res %0d index %0d count %0d status %0d last %0d",
					$time, got.value_res, got.index, got.count, got.status, got.last);
				errors++;
				return;
			end
			want = awaited.pop_front();
			checked++;
			if (got.value_res !== want.value_res) begin
				$display("%0t: value_res expected %0d, got %0d", $time, want.value_res, got.value_res);
				errors++;
			end
			if (got.index !== want.index) begin
				$display("%0t: index expected %0d, got %0d", $time, want.index, got.index);
				errors++;
			end
			if (got.count !== want.count) begin
				$display("%0t: count expected %0d, got %0d", $time, want.count, got.count);
				errors++;
			end
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
				errors++;
			end
			if (got.last !== want.last) begin
				$display("%0t: last expected %0d, got %0d", $time, want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     cfg_wen   = 1'b0;
	logic [CAP_W-1:0]         cfg_data  = '0;
	logic                     in_valid  = 1'b0;
	logic                     in_ready;
	logic [MODE_W-1:0]        mode      = MODE_ADD;
	logic signed [DATA_W-1:0] value     = '0;
	logic [POS_W-1:0]         position  = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [DATA_W-1:0] value_res;
	logic [IDX_W-1:0]         index;
	logic [IDX_W-1:0]         count;
	logic [STATUS_W-1:0]      status;
	logic                     last;

	window_scoreboard sb;
	bit               calm          = 1'b0;
	int unsigned      cycles        = 0;
	int unsigned      requests_sent = 0;
	int unsigned      settings      = 1;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	bounded_window_buffer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.value     (value),
		.position  (position),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value_res (value_res),
		.index     (index),
		.count     (count),
		.status    (status),
		.last      (last)
	);

	// Abort a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("bounded_window_buffer: mismatch");
			$finish;
		end
	end

	// Check every result at the edge that takes it; outputs still hold pre-edge values here.
	always @(posedge clk) begin
		res_t got;
		if (arst_n && out_valid && out_ready) begin
			got.value_res = value_res;
			got.index     = index;
			got.count     = count;
			got.status    = status;
			got.last      = last;
			sb.check_result(got);
		end
	end

	// Result side: hold off the block in random bursts, none once the run goes calm.
	initial begin
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 9) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// Present one request and hold it until the block takes it. A random gap may come
	// first; otherwise valid stays high straight from the previous request.
	task automatic send_request(input logic [MODE_W-1:0] op,
			input logic signed [DATA_W-1:0] v, input logic [POS_W-1:0] pos);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode     <= op;
		value    <= v;
		position <= pos;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_request(op, v, pos);
		requests_sent++;
	endtask

	// Write capacity only with the block quiet: drain every result, then let any
	// trailing gap close or ignored request run out before the write.
	task automatic load_capacity(input logic [CAP_W-1:0] c);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wen  <= 1'b1;
		cfg_data <= c;
		@(posedge clk);
		cfg_wen  <= 1'b0;
		sb.set_capacity(c);
		settings++;
	endtask

	// Mostly legal traffic: adds, removes aimed inside the window and dumps, with some
	// out-of-range removes and unused-mode requests as noise.
	task automatic random_requests(input int unsigned n);
		logic [MODE_W-1:0]        op;
		logic signed [DATA_W-1:0] v;
		logic [POS_W-1:0]         pos;
		int unsigned              pick;
		repeat (n) begin
			pick = $urandom_range(0, 99);
			v    = $urandom;
			pos  = POS_W'($urandom);
			if ($urandom_range(0, 7) == 0) begin
				case ($urandom_range(0, 3))
					0: v = 32'sh7FFF_FFFF;
					1: v = 32'sh8000_0000;
					2: v = 32'sh0000_0000;
					default: v = 32'shFFFF_FFFF;
				endcase
			end
			if (pick < 45) begin
				op = MODE_ADD;
			end else if (pick < 70 && sb.fill() != 0) begin
				op  = MODE_REMOVE;
				pos = POS_W'($urandom_range(1, sb.fill()));
			end else if (pick < 80) begin
				op = MODE_REMOVE;
			end else if (pick < 96) begin
				op = MODE_DUMP;
			end else begin
				op = MODE_UNUSED;
			end
			send_request(op, v, pos);
		end
	endtask

	initial begin
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset capacity: empty window first, then extremes and every remove outcome.
		send_request(MODE_DUMP,   32'sd0, 5'd0);
		send_request(MODE_REMOVE, 32'sd0, 5'd0);
		send_request(MODE_UNUSED, 32'sh7FFF_FFFF, 5'd31);
		send_request(MODE_ADD,    32'sh7FFF_FFFF, 5'd0);
		send_request(MODE_ADD,    32'sh8000_0000, 5'd31);
		send_request(MODE_ADD,    32'sh0000_0000, 5'd0);
		send_request(MODE_ADD,    32'shFFFF_FFFF, 5'd0);
		send_request(MODE_REMOVE, 32'sd0, 5'd31);
		send_request(MODE_REMOVE, 32'sd0, 5'd5);
		send_request(MODE_REMOVE, 32'sd0, 5'd4);
		send_request(MODE_REMOVE, 32'sd0, 5'd2);
		send_request(MODE_DUMP,   32'sd0, 5'd0);

		// Small window: the second add overflows and drops the oldest.
		load_capacity(5'd3);
		send_request(MODE_ADD,  32'sh1234_5678, 5'd0);
		send_request(MODE_ADD,  -32'sd5, 5'd0);
		send_request(MODE_DUMP, 32'sd0, 5'd0);

		// Lower capacity under the fill: the dump still shows three, then the add trims
		// to one slot and each further add replaces it.
		load_capacity(5'd1);
		send_request(MODE_DUMP, 32'sd0, 5'd0);
		send_request(MODE_ADD,  32'sh0BAD_F00D, 5'd0);
		send_request(MODE_ADD,  -32'sd77, 5'd0);
		send_request(MODE_DUMP, 32'sd0, 5'd0);

		// Random traffic across capacities, the out-of-range ones included.
		load_capacity(5'd16);
		random_requests(16);
		load_capacity(5'd0);
		random_requests(10);
		load_capacity(5'd31);
		random_requests(16);
		load_capacity(5'd5);
		random_requests(12);
		load_capacity(5'd2);
		random_requests(10);
		load_capacity(5'd12);
		calm = 1'b1;
		random_requests(18);

		// Drain, then give the block time to show any stray result.
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d requests sent, %0d results checked, %0d capacity settings",
			requests_sent, sb.checked, settings);
		$display("stalls on both channels, final phase back to back");
		if (sb.errors == 0)
			$display("bounded_window_buffer: match");
		else
			$display("bounded_window_buffer: mismatch");
		$finish;
	end

endmodule
